// ----- rtl/core/comment_stripper_core_assert.svh -----
// assertion macros shared by the comment stripper rtl
`ifndef COMMENT_STRIPPER_CORE_ASSERT_SVH
`define COMMENT_STRIPPER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CS_ASSERT(lbl, prop, msg)
`define CS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/core/cs_pkg.sv -----
// types and constants for the comment stripper
`default_nettype none

package cs_pkg;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChNl    = 8'h0A;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_LINE  = 3'b010,
    MODE_BLOCK = 3'b100
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } cs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } cs_out_t;

  // one or two results produced by one input beat
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       valid0;
    logic [7:0] byte1;
    logic       eot;
  } cs_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/cs_front.sv -----
// front end: scanner state and classification of each input beat
`default_nettype none

`include "comment_stripper_core_assert.svh"

module cs_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             accept_i,
  input  cs_pkg::cs_in_t  in_i,
  output logic            wr_en_o,
  output cs_pkg::cs_entry_t entry_o
);

  cs_pkg::mode_e mode_q, mode_d;
  logic          star_q, star_d;
  logic          slash_q, slash_d;

  logic [7:0] b;
  logic       last;
  logic       rel;
  logic       emit;

  assign b    = in_i.in_byte;
  assign last = in_i.in_last;

  always_comb begin
    mode_d  = mode_q;
    star_d  = star_q;
    slash_d = slash_q;
    rel     = 1'b0;
    emit    = 1'b0;
    case (mode_q)
      cs_pkg::MODE_BLOCK: begin
        if (star_q && b == cs_pkg::ChSlash) begin
          mode_d = cs_pkg::MODE_PLAIN;
          star_d = 1'b0;
        end else begin
          star_d = (b == cs_pkg::ChStar);
        end
      end
      cs_pkg::MODE_LINE: begin
        if (b == cs_pkg::ChNl) begin
          emit   = 1'b1;
          mode_d = cs_pkg::MODE_PLAIN;
        end
      end
      default: begin
        mode_d = cs_pkg::MODE_PLAIN;
        if (slash_q && b == cs_pkg::ChStar) begin
          slash_d = 1'b0;
          mode_d  = cs_pkg::MODE_BLOCK;
          star_d  = 1'b0;
        end else begin
          rel     = slash_q;
          slash_d = 1'b0;
          if (b == cs_pkg::ChSlash) begin
            if (last) begin
              emit = 1'b1;
            end else begin
              slash_d = 1'b1;
            end
          end else if (b == cs_pkg::ChHash) begin
            mode_d = cs_pkg::MODE_LINE;
          end else begin
            emit = 1'b1;
          end
        end
      end
    endcase
    // end of text returns to the reset state
    if (last) begin
      mode_d  = cs_pkg::MODE_PLAIN;
      star_d  = 1'b0;
      slash_d = 1'b0;
    end
  end

  always_comb begin
    entry_o.two    = rel & emit;
    entry_o.byte0  = rel ? cs_pkg::ChSlash : (emit ? b : 8'h00);
    entry_o.valid0 = rel | emit;
    entry_o.byte1  = b;
    entry_o.eot    = last;
    wr_en_o        = accept_i & (rel | emit | last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cs_pkg::MODE_PLAIN;
      star_q  <= 1'b0;
      slash_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      star_q  <= star_d;
      slash_q <= slash_d;
    end
  end

  `CS_ASSERT(a_slash_plain, slash_q |-> mode_q == cs_pkg::MODE_PLAIN, "held slash outside plain")
  `CS_ASSERT(a_star_block, star_q |-> mode_q == cs_pkg::MODE_BLOCK, "star flag outside block")

endmodule

`default_nettype wire

// ----- rtl/core/cs_queue.sv -----
// short queue of result entries between front and back
`default_nettype none

`include "comment_stripper_core_assert.svh"

module cs_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               wr_en_i,
  input  cs_pkg::cs_entry_t wr_data_i,
  output logic              full_o,
  input  wire               rd_en_i,
  output logic              nonempty_o,
  output cs_pkg::cs_entry_t rd_data_o
);

  cs_pkg::cs_entry_t mem_q [cs_pkg::QDepth];

  logic [cs_pkg::QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [cs_pkg::QCw-1:0] count_q, count_d;

  assign full_o     = (count_q == cs_pkg::QCw'(cs_pkg::QDepth));
  assign nonempty_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  `CS_ASSERT_NEVER(a_no_overflow, wr_en_i && full_o, "queue write while full")
  `CS_ASSERT_NEVER(a_no_underflow, rd_en_i && !nonempty_o, "queue read while empty")

endmodule

`default_nettype wire

// ----- rtl/core/cs_back.sv -----
// back end: output register that hands out one result per beat
`default_nettype none

`include "comment_stripper_core_assert.svh"

module cs_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               q_nonempty_i,
  input  cs_pkg::cs_entry_t q_data_i,
  output logic              q_rd_o,
  output logic              empty_o,
  input  wire               pop_i,
  output cs_pkg::cs_out_t   out_o
);

  cs_pkg::cs_entry_t ent_q;
  logic              busy_q;
  logic              phase_q;
  logic              fire;
  logic              last_res;
  logic              load;

  assign empty_o  = !busy_q;
  assign fire     = pop_i & busy_q;
  assign last_res = !ent_q.two | phase_q;
  assign load     = q_nonempty_i & (!busy_q | (fire & last_res));
  assign q_rd_o   = load;

  always_comb begin
    if (phase_q) begin
      out_o.out_byte    = ent_q.byte1;
      out_o.byte_valid  = 1'b1;
      out_o.end_of_text = ent_q.eot;
    end else begin
      out_o.out_byte    = ent_q.byte0;
      out_o.byte_valid  = ent_q.valid0;
      out_o.end_of_text = ent_q.eot & !ent_q.two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      busy_q  <= 1'b1;
      phase_q <= 1'b0;
    end else if (fire) begin
      busy_q  <= !last_res;
      phase_q <= !last_res;
    end
  end

  `CS_ASSERT(a_phase_two, phase_q |-> busy_q && ent_q.two, "second beat without pair entry")

endmodule

`default_nettype wire

// ----- rtl/core/comment_stripper_core.sv -----
// top level of the streaming comment stripper
`default_nettype none

// Text enters one byte per beat and leaves with '#' line comments and
// '/*...*/' block comments removed. The scanner takes a byte every cycle
// while its four-entry result queue has room; each byte yields zero, one
// or two result beats, and the output register hands out one result beat
// per cycle while pop is held, so a byte that releases a held '/' together
// with itself yields two output beats. A result is written into the queue
// and then loaded into the output register, where it can be popped.
// The final byte of a text always gives at least one result beat, flagged
// end_of_text, and the scanner then restarts in plain text.
module comment_stripper_core (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push,
  output logic            full,
  input  cs_pkg::cs_in_t  in_i,
  output logic            empty,
  input  wire             pop,
  output cs_pkg::cs_out_t out_o
);

  logic              accept;
  logic              wr_en;
  cs_pkg::cs_entry_t wr_entry;
  logic              q_full;
  logic              q_rd;
  logic              q_nonempty;
  cs_pkg::cs_entry_t q_data;

  assign full   = q_full;
  assign accept = push & !q_full;

  cs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .wr_en_o  (wr_en),
    .entry_o  (wr_entry)
  );

  cs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_data_i  (wr_entry),
    .full_o     (q_full),
    .rd_en_i    (q_rd),
    .nonempty_o (q_nonempty),
    .rd_data_o  (q_data)
  );

  cs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (q_nonempty),
    .q_data_i     (q_data),
    .q_rd_o       (q_rd),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// self-checking testbench for comment_stripper_core with its own stripping predictor
`default_nettype none

module tb;
  import cs_pkg::*;

  localparam int unsigned TotalBeats = 950;
  localparam int unsigned CalmBeats  = 150;
  localparam int unsigned DrainAt    = 450;
  localparam int unsigned StallLimit = 1000;

  typedef struct packed {
    cs_in_t     beat;
    logic       typed;
    logic [1:0] n;
    cs_out_t    r0;
    cs_out_t    r1;
  } row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  logic    full;
  logic    empty;
  cs_in_t  text_in = '0;
  cs_out_t text_out;

  comment_stripper_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (text_in),
    .empty (empty),
    .pop   (pop),
    .out_o (text_out)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  mode_e   scan_st = MODE_PLAIN;
  bit      star_st = 1'b0;
  bit      slash_held = 1'b0;

  cs_out_t stripped_q[$];
  row_t    plan[$];
  int      mismatches = 0;
  int      beats_in = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  int      run_left = 0;
  bit      calm = 1'b0;
  cs_out_t want;

  function automatic int strip_byte(input cs_in_t b, output cs_out_t res[2]);
    int n;
    bit opened;
    n = 0;
    opened = 1'b0;
    res[0] = '0;
    res[1] = '0;
    case (scan_st)
      MODE_BLOCK: begin
        if (star_st && b.in_byte == ChSlash) begin
          scan_st = MODE_PLAIN;
          star_st = 1'b0;
        end else begin
          star_st = (b.in_byte == ChStar);
        end
      end
      MODE_LINE: begin
        if (b.in_byte == ChNl) begin
          res[n] = {b.in_byte, 1'b1, 1'b0};
          n++;
          scan_st = MODE_PLAIN;
        end
      end
      default: begin
        scan_st = MODE_PLAIN;
        if (slash_held) begin
          slash_held = 1'b0;
          if (b.in_byte == ChStar) begin
            scan_st = MODE_BLOCK;
            star_st = 1'b0;
            opened = 1'b1;
          end else begin
            res[n] = {ChSlash, 1'b1, 1'b0};
            n++;
          end
        end
        if (!opened) begin
          if (b.in_byte == ChSlash) begin
            if (b.in_last) begin
              res[n] = {b.in_byte, 1'b1, 1'b0};
              n++;
            end else begin
              slash_held = 1'b1;
            end
          end else if (b.in_byte == ChHash) begin
            scan_st = MODE_LINE;
          end else begin
            res[n] = {b.in_byte, 1'b1, 1'b0};
            n++;
          end
        end
      end
    endcase
    if (b.in_last) begin
      if (n == 0) begin
        res[0] = {8'h00, 1'b0, 1'b0};
        n = 1;
      end
      res[n-1].end_of_text = 1'b1;
      scan_st = MODE_PLAIN;
      star_st = 1'b0;
      slash_held = 1'b0;
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic row(input logic [7:0] ch, input logic last, input logic typed,
                     input logic [1:0] n, input cs_out_t r0, input cs_out_t r1);
    plan.push_back({ch, last, typed, n, r0, r1});
  endtask

  // drive one beat, wait for it to be taken, then queue what it should produce
  task automatic feed(input row_t r);
    cs_out_t res[2];
    int n;
    @(negedge clk_i);
    push <= 1'b1;
    text_in <= r.beat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_in++;
    n = strip_byte(r.beat, res);
    if (r.typed) begin
      if (r.n > 0) stripped_q.push_back(r.r0);
      if (r.n > 1) stripped_q.push_back(r.r1);
    end else begin
      for (int i = 0; i < n; i++) stripped_q.push_back(res[i]);
    end
    calm = (beats_in >= TotalBeats - CalmBeats);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 9))
      0, 1:    return ChSlash;
      2, 3:    return ChStar;
      4:       return ChHash;
      5:       return ChNl;
      9:       return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // result side: random stall bursts, no new ones once the run calms down
  always @(negedge clk_i) begin
    if (stall_left == 0 && run_left == 0) begin
      if (!calm && $urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 15);
      else run_left = $urandom_range(1, 30);
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      run_left--;
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (stripped_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat %h", text_out));
      end else begin
        want = stripped_q.pop_front();
        if (text_out.out_byte !== want.out_byte)
          flag_mismatch($sformatf("out_byte %h, want %h", text_out.out_byte, want.out_byte));
        if (text_out.byte_valid !== want.byte_valid)
          flag_mismatch($sformatf("byte_valid %b, want %b",
                                  text_out.byte_valid, want.byte_valid));
        if (text_out.end_of_text !== want.end_of_text)
          flag_mismatch($sformatf("end_of_text %b, want %b",
                                  text_out.end_of_text, want.end_of_text));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int len;
    bit drained;
    row_t r;
    drained = 1'b0;

    // plain bytes and extremes
    row(8'h61, 1'b0, 1'b1, 2'd1, {8'h61, 1'b1, 1'b0}, '0);
    row(8'h00, 1'b0, 1'b1, 2'd1, {8'h00, 1'b1, 1'b0}, '0);
    row(8'hFF, 1'b0, 1'b1, 2'd1, {8'hFF, 1'b1, 1'b0}, '0);
    // held slash released by another slash, then by a letter
    row(ChSlash, 1'b0, 1'b1, 2'd0, '0, '0);
    row(ChSlash, 1'b0, 1'b1, 2'd1, {ChSlash, 1'b1, 1'b0}, '0);
    row(8'h62, 1'b0, 1'b1, 2'd2, {ChSlash, 1'b1, 1'b0}, {8'h62, 1'b1, 1'b0});
    // block comment, opener star not a closer, hash inside, star star slash
    row(ChSlash, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChStar, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChSlash, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChHash, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChStar, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChStar, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChSlash, 1'b0, 1'b0, 2'd0, '0, '0);
    // star right after a closed comment
    row(ChStar, 1'b0, 1'b0, 2'd0, '0, '0);
    // line comment with a block opener inside
    row(ChHash, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChSlash, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChStar, 1'b0, 1'b0, 2'd0, '0, '0);
    row(ChNl, 1'b0, 1'b0, 2'd0, '0, '0);
    // text ends inside a line comment
    row(ChHash, 1'b0, 1'b0, 2'd0, '0, '0);
    row(8'h7A, 1'b1, 1'b1, 2'd1, {8'h00, 1'b0, 1'b1}, '0);
    // slash as the final byte
    row(ChSlash, 1'b1, 1'b1, 2'd1, {ChSlash, 1'b1, 1'b1}, '0);
    // held slash released at the final byte
    row(ChSlash, 1'b0, 1'b1, 2'd0, '0, '0);
    row(8'h63, 1'b1, 1'b1, 2'd2, {ChSlash, 1'b1, 1'b0}, {8'h63, 1'b1, 1'b1});
    // text ends right after a block opener
    row(ChSlash, 1'b0, 1'b1, 2'd0, '0, '0);
    row(ChStar, 1'b1, 1'b1, 2'd1, {8'h00, 1'b0, 1'b1}, '0);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) feed(plan[i]);

    while (beats_in < TotalBeats) begin
      if (!drained && beats_in >= DrainAt) begin
        drained = 1'b1;
        @(negedge clk_i);
        push <= 1'b0;
        while (stripped_q.size() != 0) @(posedge clk_i);
      end
      r = '0;
      if ($urandom_range(0, 7) == 0) begin
        // noise beat
        r.beat = {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
        feed(r);
      end else begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
          r.beat = {text_char(), (i == len - 1)};
          feed(r);
        end
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (stripped_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
